// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked only while reset is low.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/mbq_pkg.sv =====
package mbq_pkg;

   localparam int TASK_COUNT_DEF    = 16;
   localparam int MAILBOX_DEPTH_DEF = 8;
   localparam int PAYLOAD_BITS_DEF  = 32;

   localparam int ACTION_BITS  = 2;
   localparam int ID_BITS      = 8;
   localparam int MSG_BITS     = 32;
   localparam int STATUS_BITS  = 3;

   // Action codes; the unused code behaves as a non-blocking receive.
   localparam logic [ACTION_BITS-1:0] ACT_SEND      = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_RECV_WAIT = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_RECV_POLL = 2'd2;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK      = 3'd0,
      STAT_BAD_ID  = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_NO_TASK = 3'd3,
      STAT_EMPTY   = 3'd4,
      STAT_WAIT    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_DONE
   } fsm_type;

endpackage

// ===== rtl/core/mbq_req_if.sv =====
interface mbq_req_if;
   logic                              valid;
   logic                              ready;
   logic [mbq_pkg::ACTION_BITS-1:0]   action;
   logic [mbq_pkg::ID_BITS-1:0]       task_id;
   logic [mbq_pkg::MSG_BITS-1:0]      payload;

   modport source (output valid, action, task_id, payload, input ready);
   modport sink   (input valid, action, task_id, payload, output ready);
endinterface

// ===== rtl/core/mbq_rsp_if.sv =====
interface mbq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [mbq_pkg::STATUS_BITS-1:0]   status;
   logic [mbq_pkg::MSG_BITS-1:0]      message_out;
   logic [mbq_pkg::ID_BITS-1:0]       receiver_out;

   modport source (output valid, status, message_out, receiver_out, input ready);
   modport sink   (input valid, status, message_out, receiver_out, output ready);
endinterface

// ===== rtl/core/per_task_mailbox_queues_core.sv =====
// Per-task mailbox queues. Each of TASK_COUNT tasks owns a ring buffer of
// MAILBOX_DEPTH messages in a shared message memory; its read pointer, write
// pointer and fill count sit together in one word of a pointer memory. An item
// passes through the idle, lookup and done states in turn: acceptance in idle
// reads the pointer word, lookup decides and writes back (and, for a receive,
// reads the message memory), and done loads the result register. Items are
// handled one at a time, so the input takes no new item until the last one
// has left the done state; a new item is accepted while the previous result
// still waits in the output register, and it then holds after its lookup
// until that register is free. Pointer words start out empty through per-task
// valid bits that reset clears, so there is no clearing pass after reset. A
// blocking receive on an empty mailbox answers wait and the requester retries.
`include "assert_macros.svh"

module per_task_mailbox_queues_core #(
   parameter int TASK_COUNT    = mbq_pkg::TASK_COUNT_DEF,
   parameter int MAILBOX_DEPTH = mbq_pkg::MAILBOX_DEPTH_DEF,
   parameter int PAYLOAD_BITS  = mbq_pkg::PAYLOAD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   mbq_req_if.sink   req_chan,
   mbq_rsp_if.source rsp_chan
);

   localparam int QW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int PW = $clog2(MAILBOX_DEPTH);
   localparam int CW = $clog2(MAILBOX_DEPTH + 1);
   localparam int EW = 2 * PW + CW;
   localparam int MSG_DEPTH = TASK_COUNT * MAILBOX_DEPTH;
   localparam int AW = $clog2(MSG_DEPTH);
   localparam int IDW = mbq_pkg::ID_BITS;

   mbq_pkg::fsm_type state_ff, state_in;

   logic [mbq_pkg::ACTION_BITS-1:0] action_ff, action_in;
   logic [IDW-1:0]                  id_ff, id_in;
   logic [PAYLOAD_BITS-1:0]         payload_ff, payload_in;
   logic [QW-1:0]                   q_ff, q_in;
   mbq_pkg::status_type             pend_status_ff, pend_status_in;
   logic                            pend_pop_ff, pend_pop_in;
   logic [TASK_COUNT-1:0]           valid_ff, valid_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   mbq_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [mbq_pkg::MSG_BITS-1:0]    rsp_msg_ff, rsp_msg_in;
   logic [IDW-1:0]                  rsp_rcv_ff, rsp_rcv_in;

   logic                 ptr_re, ptr_we;
   logic [EW-1:0]        ptr_rdata, ptr_wdata, entry;
   logic                 msg_re, msg_we;
   logic [AW-1:0]        msg_waddr, msg_raddr;
   logic [PAYLOAD_BITS-1:0] msg_rdata;

   logic [PW-1:0]        rd_ptr, wr_ptr, rd_next, wr_next;
   logic [CW-1:0]        cnt;
   logic                 id_zero, id_high, out_free, accept;
   logic [63:0]          pay_wide, msg_wide;

   mbq_ram #(.WIDTH(EW), .DEPTH(TASK_COUNT)) u_ptr_ram (
      .clock (clock),
      .we    (ptr_we),
      .waddr (q_ff),
      .wdata (ptr_wdata),
      .re    (ptr_re),
      .raddr (q_in),
      .rdata (ptr_rdata)
   );

   mbq_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(MSG_DEPTH)) u_msg_ram (
      .clock (clock),
      .we    (msg_we),
      .waddr (msg_waddr),
      .wdata (payload_ff),
      .re    (msg_re),
      .raddr (msg_raddr),
      .rdata (msg_rdata)
   );

   // A task whose word was never written reads as empty.
   assign entry  = valid_ff[q_ff] ? ptr_rdata : '0;
   assign rd_ptr = entry[EW-1 -: PW];
   assign wr_ptr = entry[CW +: PW];
   assign cnt    = entry[CW-1:0];
   assign rd_next = (rd_ptr == PW'(MAILBOX_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
   assign wr_next = (wr_ptr == PW'(MAILBOX_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);

   assign id_zero  = (id_ff == '0);
   assign id_high  = ({1'b0, id_ff} > (IDW + 1)'(TASK_COUNT));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;

   assign pay_wide  = 64'(req_chan.payload);
   assign msg_wide  = 64'(msg_rdata);
   assign msg_waddr = AW'(q_ff) * AW'(MAILBOX_DEPTH) + AW'(wr_ptr);
   assign msg_raddr = AW'(q_ff) * AW'(MAILBOX_DEPTH) + AW'(rd_ptr);

   assign req_chan.ready = (state_ff == mbq_pkg::FSM_IDLE);

   always_comb begin
      state_in       = state_ff;
      action_in      = action_ff;
      id_in          = id_ff;
      payload_in     = payload_ff;
      q_in           = q_ff;
      pend_status_in = pend_status_ff;
      pend_pop_in    = pend_pop_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_msg_in     = rsp_msg_ff;
      rsp_rcv_in     = rsp_rcv_ff;
      ptr_re         = 1'b0;
      ptr_we         = 1'b0;
      ptr_wdata      = entry;
      msg_re         = 1'b0;
      msg_we         = 1'b0;

      case (state_ff)
         mbq_pkg::FSM_IDLE: begin
            if (accept) begin
               action_in  = req_chan.action;
               id_in      = req_chan.task_id;
               payload_in = pay_wide[PAYLOAD_BITS-1:0];
               q_in       = QW'(req_chan.task_id - IDW'(1));
               ptr_re     = 1'b1;
               state_in   = mbq_pkg::FSM_LOOKUP;
            end
         end
         mbq_pkg::FSM_LOOKUP: begin
            pend_pop_in = 1'b0;
            if (action_ff == mbq_pkg::ACT_SEND) begin
               if (id_zero || id_high) begin
                  pend_status_in = mbq_pkg::STAT_BAD_ID;
               end else if (cnt >= CW'(MAILBOX_DEPTH)) begin
                  pend_status_in = mbq_pkg::STAT_FULL;
               end else begin
                  pend_status_in   = mbq_pkg::STAT_OK;
                  msg_we           = 1'b1;
                  ptr_we           = 1'b1;
                  ptr_wdata        = {rd_ptr, wr_next, cnt + CW'(1)};
                  valid_in[q_ff]   = 1'b1;
               end
            end else if (id_zero) begin
               pend_status_in = mbq_pkg::STAT_NO_TASK;
            end else if (id_high) begin
               pend_status_in = mbq_pkg::STAT_BAD_ID;
            end else if (cnt == '0) begin
               pend_status_in = (action_ff == mbq_pkg::ACT_RECV_WAIT) ?
                                mbq_pkg::STAT_WAIT : mbq_pkg::STAT_EMPTY;
            end else begin
               pend_status_in = mbq_pkg::STAT_OK;
               pend_pop_in    = 1'b1;
               msg_re         = 1'b1;
               ptr_we         = 1'b1;
               ptr_wdata      = {rd_next, wr_ptr, cnt - CW'(1)};
               valid_in[q_ff] = 1'b1;
            end
            state_in = mbq_pkg::FSM_DONE;
         end
         mbq_pkg::FSM_DONE: begin
            // message memory output holds until this loads
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_msg_in    = pend_pop_ff ? msg_wide[mbq_pkg::MSG_BITS-1:0] : '0;
               rsp_rcv_in    = pend_pop_ff ? id_ff : '0;
               state_in      = mbq_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = mbq_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbq_pkg::FSM_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff      <= action_in;
      id_ff          <= id_in;
      payload_ff     <= payload_in;
      q_ff           <= q_in;
      pend_status_ff <= pend_status_in;
      pend_pop_ff    <= pend_pop_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_msg_ff     <= rsp_msg_in;
      rsp_rcv_ff     <= rsp_rcv_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.message_out  = rsp_msg_ff;
   assign rsp_chan.receiver_out = rsp_rcv_ff;

   `ASSERT_CLK(a_cnt_bound, clock, reset, ptr_we |-> (ptr_wdata[CW-1:0] <= CW'(MAILBOX_DEPTH)), "fill count overflow")
   `ASSERT_CLK(a_pop_nonempty, clock, reset, msg_re |-> (cnt != '0), "pop from empty mailbox")
   `ASSERT_CLK(a_done_loads, clock, reset, (state_ff == mbq_pkg::FSM_DONE && out_free) |=> rsp_valid_ff, "result not loaded")
   `ASSERT_CLK(a_zero_fields, clock, reset, (rsp_valid_ff && rsp_status_ff != mbq_pkg::STAT_OK) |-> (rsp_msg_ff == '0 && rsp_rcv_ff == '0), "fields set on failure")
   `ASSERT_ALWAYS(a_no_mem_in_idle, clock, (state_ff == mbq_pkg::FSM_IDLE) |-> (!ptr_we && !msg_we && !msg_re), "memory access while idle")

endmodule

// ===== rtl/core/mbq_ram.sv =====
module mbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      // read data holds until the next read
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== test/tb_per_task_mailbox_queues_core.sv =====
module tb_per_task_mailbox_queues_core;

   localparam int TASKS = mbq_pkg::TASK_COUNT_DEF;
   localparam int DEPTH = mbq_pkg::MAILBOX_DEPTH_DEF;
   localparam int AB    = mbq_pkg::ACTION_BITS;
   localparam int IB    = mbq_pkg::ID_BITS;
   localparam int MB    = mbq_pkg::MSG_BITS;
   // Spare action code; the block treats it as a non-blocking receive.
   localparam logic [AB-1:0] ACT_SPARE = 2'd3;

   typedef struct {
      mbq_pkg::status_type status;
      logic [MB-1:0]       message;
      logic [IB-1:0]       receiver;
   } reply_type;

   logic clock;
   logic reset;

   mbq_req_if req_bus ();
   mbq_rsp_if rsp_bus ();

   per_task_mailbox_queues_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the per-task ring buffers.
   logic [MB-1:0] box_data [TASKS][DEPTH];
   int            box_rd   [TASKS];
   int            box_wr   [TASKS];
   int            box_fill [TASKS];

   reply_type replies_due [$];
   int        fail_count = 0;
   logic      idle_en;
   logic      rsp_hold;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic reply_type mbox_reply(input logic [AB-1:0] act,
                                            input logic [IB-1:0] id,
                                            input logic [MB-1:0] data);
      reply_type r;
      int        q;
      r.status   = mbq_pkg::STAT_OK;
      r.message  = '0;
      r.receiver = '0;
      if (act == mbq_pkg::ACT_SEND) begin
         if (id == 0 || id > TASKS) begin
            r.status = mbq_pkg::STAT_BAD_ID;
         end else begin
            q = id - 1;
            if (box_fill[q] >= DEPTH) begin
               r.status = mbq_pkg::STAT_FULL;
            end else begin
               box_data[q][box_wr[q]] = data;
               box_wr[q]   = (box_wr[q] + 1) % DEPTH;
               box_fill[q] = box_fill[q] + 1;
            end
         end
      end else if (id == 0) begin
         r.status = mbq_pkg::STAT_NO_TASK;
      end else if (id > TASKS) begin
         r.status = mbq_pkg::STAT_BAD_ID;
      end else begin
         q = id - 1;
         if (box_fill[q] == 0) begin
            r.status = (act == mbq_pkg::ACT_RECV_WAIT) ? mbq_pkg::STAT_WAIT
                                                       : mbq_pkg::STAT_EMPTY;
         end else begin
            r.message   = box_data[q][box_rd[q]];
            r.receiver  = id;
            box_rd[q]   = (box_rd[q] + 1) % DEPTH;
            box_fill[q] = box_fill[q] - 1;
         end
      end
      return r;
   endfunction

   // Offers one item and returns at the edge where it is taken.
   task automatic send_item(input logic [AB-1:0] act,
                            input logic [IB-1:0] id,
                            input logic [MB-1:0] data);
      if (idle_en && $urandom_range(0, 99) < 27) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while (idle_en && $urandom_range(0, 99) < 27);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.task_id <= id;
      req_bus.payload <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      replies_due.push_back(mbox_reply(act, id, data));
   endtask

   // Result side: check what was taken at this edge, then pick the next ready.
   initial begin
      reply_type want;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (replies_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result with nothing outstanding: status %0d msg %h rcv %0d",
                           $realtime, rsp_bus.status, rsp_bus.message_out,
                           rsp_bus.receiver_out);
            end else begin
               want = replies_due.pop_front();
               if (rsp_bus.status !== want.status || rsp_bus.message_out !== want.message ||
                   rsp_bus.receiver_out !== want.receiver) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: expected status %0d msg %h rcv %0d, got %0d %h %0d",
                              $realtime, want.status, want.message, want.receiver,
                              rsp_bus.status, rsp_bus.message_out, rsp_bus.receiver_out);
               end
            end
         end
         rsp_bus.ready <= !rsp_hold && !(idle_en && $urandom_range(0, 99) < 27);
      end
   end

   task automatic test_bad_ids;
      send_item(mbq_pkg::ACT_SEND, 8'd0, 32'h1234_5678);
      send_item(mbq_pkg::ACT_SEND, 8'd255, 32'hFFFF_FFFF);
      send_item(mbq_pkg::ACT_RECV_WAIT, 8'd0, 32'h0);
      send_item(mbq_pkg::ACT_RECV_POLL, 8'd255, 32'h0);
      send_item(ACT_SPARE, 8'd17, 32'h0);
   endtask

   task automatic test_empty_boxes;
      send_item(mbq_pkg::ACT_RECV_POLL, 8'd1, 32'h0);
      send_item(ACT_SPARE, 8'd1, 32'hFFFF_FFFF);
      // blocking receive answers wait, then succeeds once a message is there
      send_item(mbq_pkg::ACT_RECV_WAIT, 8'd2, 32'h0);
      send_item(mbq_pkg::ACT_SEND, 8'd2, 32'hA5A5_5A5A);
      send_item(mbq_pkg::ACT_RECV_WAIT, 8'd2, 32'h0);
   endtask

   task automatic test_full_box;
      int i;
      for (i = 0; i < DEPTH; i++)
         send_item(mbq_pkg::ACT_SEND, 8'(TASKS),
                   (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom);
      send_item(mbq_pkg::ACT_SEND, 8'(TASKS), 32'hDEAD_BEEF);
      send_item(mbq_pkg::ACT_RECV_WAIT, 8'(TASKS), 32'h0);
      send_item(mbq_pkg::ACT_RECV_POLL, 8'(TASKS), 32'h0);
      send_item(ACT_SPARE, 8'(TASKS), 32'h0);
      // write pointer has wrapped; these sends reuse slots the receives freed
      send_item(mbq_pkg::ACT_SEND, 8'(TASKS), 32'h8000_0001);
      send_item(mbq_pkg::ACT_SEND, 8'(TASKS), 32'h7FFF_FFFE);
   endtask

   // Bursts of 50 items lean toward sends or receives and toward one task,
   // so mailboxes fill, drain and wrap; a few items are malformed.
   task automatic test_random_traffic(input int n_items);
      int              i;
      int              send_pct;
      int              hot_task;
      logic [AB-1:0]   act;
      logic [IB-1:0]   id;
      send_pct = 50;
      hot_task = 1;
      for (i = 0; i < n_items; i++) begin
         if (i % 50 == 0) begin
            send_pct = $urandom_range(20, 80);
            hot_task = $urandom_range(1, TASKS);
         end
         if ($urandom_range(0, 99) < 8) begin
            act = AB'($urandom);
            id  = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
         end else begin
            if ($urandom_range(0, 99) < send_pct)
               act = mbq_pkg::ACT_SEND;
            else
               case ($urandom_range(0, 5))
                  0, 1, 2: act = mbq_pkg::ACT_RECV_WAIT;
                  3, 4:    act = mbq_pkg::ACT_RECV_POLL;
                  default: act = ACT_SPARE;
               endcase
            id = $urandom_range(0, 1) ? 8'(hot_task) : 8'($urandom_range(1, TASKS));
         end
         send_item(act, id, $urandom);
      end
   endtask

   task automatic test_backpressure;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      test_random_traffic(60);
   endtask

   task automatic test_no_idle;
      idle_en <= 1'b0;
      test_random_traffic(300);
      idle_en <= 1'b1;
   endtask

   initial begin
      foreach (box_fill[t]) begin
         box_rd[t]   = 0;
         box_wr[t]   = 0;
         box_fill[t] = 0;
      end
      idle_en         <= 1'b1;
      rsp_hold        <= 1'b0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.action  <= mbq_pkg::ACT_SEND;
      req_bus.task_id <= '0;
      req_bus.payload <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_bad_ids();
      test_empty_boxes();
      test_full_box();
      test_random_traffic(600);
      test_backpressure();
      test_no_idle();
      test_random_traffic(400);

      req_bus.valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
